// File: rtl/core/smcp_pkg.sv
// Package for the serial motor command parser: command codes, result type, setpoint conversion.
package smcp_pkg;

  localparam logic [7:0] CMD_GO   = 8'h67;  // 'g'
  localparam logic [7:0] CMD_STOP = 8'h73;  // 's'
  localparam logic [7:0] CMD_SYNC = 8'h75;  // 'u'

  localparam int unsigned FRAME_STORE = 5;   // bytes held before the closing byte
  localparam logic [2:0]  LAST_INDEX  = 3'd5;

  typedef struct packed {
    logic [7:0]         tx_byte;
    logic               tx_twice;
    logic               run_flag;
    logic               stop_flag;
    logic               setpoints_valid;
    logic signed [15:0] setpoint_a;
    logic signed [15:0] setpoint_b;
    logic signed [15:0] setpoint_c;
  } result_t;

  // Little-endian sign-magnitude pair to two's complement; negative zero gives 0.
  function automatic logic signed [15:0] sm_to_twos(input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] raw;
    logic [15:0] mag;
    raw = {hi, lo};
    mag = {1'b0, raw[14:0]};
    if (raw[15]) begin
      sm_to_twos = 16'(16'd0 - mag);
    end else begin
      sm_to_twos = mag;
    end
  endfunction

endpackage

// File: rtl/core/serial_motor_command_parser.sv
// Serial motor command parser: byte echo, run/stop flags, setpoint frame assembly.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one received host byte per
//   transaction. Output channel (out_valid/out_ready) carries one result per byte:
//   the echo (tx_byte), tx_twice for a sync 'u', the run and stop flags after the
//   byte, setpoints_valid when the byte closed a six-byte frame, and the three
//   held setpoints in two's complement.
//   'g' sets run / clears stop, 's' sets stop / clears run, 'u' restarts the frame.
//   Any other byte is a frame byte; the sixth one loads all three setpoints.
//   Result: registered into the output register, or into the skid entry while a result
//   waits. Throughput: one byte per cycle while out_ready drains the buffer, with the
//   combinational decode and setpoint update between state and output registers.
//   Stall: a two-entry output buffer (output register plus skid) lets one more
//   byte in while a result waits; in_ready drops only once the skid is full.
//   Reset: flags, frame index and setpoints clear to zero; output buffer empties.
//   Frame byte storage is not reset: a frame only reads bytes written in it.
module serial_motor_command_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         tx_byte,
  output logic               tx_twice,
  output logic               run_flag,
  output logic               stop_flag,
  output logic               setpoints_valid,
  output logic signed [15:0] setpoint_a,
  output logic signed [15:0] setpoint_b,
  output logic signed [15:0] setpoint_c
);
  import smcp_pkg::*;

  // Parser state
  logic               run_reg;
  logic               stop_reg;
  logic [2:0]         byte_index;
  logic [7:0]         frame_bytes [FRAME_STORE];
  logic signed [15:0] setpoint_regs [3];

  logic               run_next;
  logic               stop_next;
  logic [2:0]         byte_index_next;
  logic               store_byte;
  logic               frame_done;
  logic signed [15:0] sp_next [3];

  // Output buffer: main result register plus skid entry
  result_t res_next;
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;
  logic    in_fire;
  logic    out_free;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Byte decode: commands take priority over frame collection
  always_comb begin
    run_next        = run_reg;
    stop_next       = stop_reg;
    byte_index_next = byte_index;
    store_byte      = 1'b0;
    frame_done      = 1'b0;
    priority if (rx_byte == CMD_GO) begin
      run_next  = 1'b1;
      stop_next = 1'b0;
    end else if (rx_byte == CMD_STOP) begin
      run_next  = 1'b0;
      stop_next = 1'b1;
    end else if (rx_byte == CMD_SYNC) begin
      byte_index_next = 3'd0;
    end else if (byte_index >= LAST_INDEX) begin
      frame_done      = 1'b1;
      byte_index_next = 3'd0;
    end else begin
      store_byte      = 1'b1;
      byte_index_next = byte_index + 3'd1;
    end
  end

  // Setpoint conversion for a closing byte; otherwise hold
  always_comb begin
    if (frame_done) begin
      sp_next[0] = sm_to_twos(frame_bytes[0], frame_bytes[1]);
      sp_next[1] = sm_to_twos(frame_bytes[2], frame_bytes[3]);
      sp_next[2] = sm_to_twos(frame_bytes[4], rx_byte);
    end else begin
      sp_next[0] = setpoint_regs[0];
      sp_next[1] = setpoint_regs[1];
      sp_next[2] = setpoint_regs[2];
    end
  end

  always_comb begin
    res_next.tx_byte         = rx_byte;
    res_next.tx_twice        = (rx_byte == CMD_SYNC);
    res_next.run_flag        = run_next;
    res_next.stop_flag       = stop_next;
    res_next.setpoints_valid = frame_done;
    res_next.setpoint_a      = sp_next[0];
    res_next.setpoint_b      = sp_next[1];
    res_next.setpoint_c      = sp_next[2];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_reg          <= 1'b0;
      stop_reg         <= 1'b0;
      byte_index       <= 3'd0;
      setpoint_regs[0] <= '0;
      setpoint_regs[1] <= '0;
      setpoint_regs[2] <= '0;
    end else if (in_fire) begin
      run_reg          <= run_next;
      stop_reg         <= stop_next;
      byte_index       <= byte_index_next;
      setpoint_regs[0] <= sp_next[0];
      setpoint_regs[1] <= sp_next[1];
      setpoint_regs[2] <= sp_next[2];
    end
  end

  // Frame byte store, no reset
  always_ff @(posedge clk) begin
    if (in_fire && store_byte) begin
      frame_bytes[byte_index] <= rx_byte;
    end
  end

  // Output buffer control; skid is empty whenever a transaction comes in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_free) begin
        out_data <= res_next;
      end else begin
        skid_data <= res_next;
      end
    end else if (out_free && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign tx_byte         = out_data.tx_byte;
  assign tx_twice        = out_data.tx_twice;
  assign run_flag        = out_data.run_flag;
  assign stop_flag       = out_data.stop_flag;
  assign setpoints_valid = out_data.setpoints_valid;
  assign setpoint_a      = out_data.setpoint_a;
  assign setpoint_b      = out_data.setpoint_b;
  assign setpoint_c      = out_data.setpoint_c;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds data while output register empty");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= LAST_INDEX) else $error("frame index out of range");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(run_reg && stop_reg)) else $error("run and stop both set");

  a_sync_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && rx_byte == CMD_SYNC) |=> (byte_index == 3'd0))
    else $error("sync byte did not restart frame");

  a_frame_reloads: assert property (@(posedge clk) disable iff (rst)
    (in_fire && frame_done) |=> (byte_index == 3'd0))
    else $error("frame completion did not restart index");

endmodule

// File: sim/tb_top.sv
// Testbench for serial_motor_command_parser: directed table plus random byte streams.
`timescale 1ns / 100ps

module tb_top;
  import smcp_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte   = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         tx_byte;
  logic               tx_twice;
  logic               run_flag;
  logic               stop_flag;
  logic               setpoints_valid;
  logic signed [15:0] setpoint_a;
  logic signed [15:0] setpoint_b;
  logic signed [15:0] setpoint_c;

  serial_motor_command_parser u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .tx_byte         (tx_byte),
    .tx_twice        (tx_twice),
    .run_flag        (run_flag),
    .stop_flag       (stop_flag),
    .setpoints_valid (setpoints_valid),
    .setpoint_a      (setpoint_a),
    .setpoint_b      (setpoint_b),
    .setpoint_c      (setpoint_c)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Upper bound on run length; the slowest legal run needs well under this.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_PER_PHASE = 625;

  // One byte offered to the parser. When 'typed' is set, 'exp' is a hand-written
  // expectation used instead of the predictor output for that transaction.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    exp;
  } rx_item_t;

  rx_item_t offered_bytes[$];   // offered on the input, not yet accepted
  result_t  pending_echoes[$];  // expected results, oldest first

  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 53;

  // ---------------------------------------------------------------------------
  // Predictor state: flags, frame collector, held setpoints.
  // Frame bytes start at zero here but are never read before being written.
  // ---------------------------------------------------------------------------
  logic               run_st    = 1'b0;
  logic               stop_st   = 1'b0;
  logic [2:0]         frame_idx = 3'd0;
  logic [7:0]         frame_buf [FRAME_STORE] = '{default: 8'h00};
  logic signed [15:0] held_sp   [3] = '{default: 16'sd0};

  // Sign-magnitude to two's complement; -0 folds to 0 by plain negation.
  function automatic logic signed [15:0] sign_mag_to_twos(input logic [7:0] lo,
                                                          input logic [7:0] hi);
    logic signed [15:0] mag;
    mag = {1'b0, hi[6:0], lo};
    return hi[7] ? -mag : mag;
  endfunction

  // Advance the predictor by one received byte and return the expected result.
  function automatic result_t parse_rx_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.tx_byte = b;
    if (b == CMD_GO) begin
      run_st  = 1'b1;
      stop_st = 1'b0;
    end else if (b == CMD_STOP) begin
      stop_st = 1'b1;
      run_st  = 1'b0;
    end else if (b == CMD_SYNC) begin
      r.tx_twice = 1'b1;
      frame_idx  = 3'd0;
    end else if (frame_idx >= LAST_INDEX) begin
      // closing byte: high byte of the third setpoint
      held_sp[0] = sign_mag_to_twos(frame_buf[0], frame_buf[1]);
      held_sp[1] = sign_mag_to_twos(frame_buf[2], frame_buf[3]);
      held_sp[2] = sign_mag_to_twos(frame_buf[4], b);
      frame_idx  = 3'd0;
      r.setpoints_valid = 1'b1;
    end else begin
      frame_buf[frame_idx] = b;
      frame_idx = frame_idx + 3'd1;
    end
    r.run_flag   = run_st;
    r.stop_flag  = stop_st;
    r.setpoint_a = held_sp[0];
    r.setpoint_b = held_sp[1];
    r.setpoint_c = held_sp[2];
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] seen);
    if (want !== seen) begin
      if (fail_cnt < MAX_REPORTS)
        $display("mismatch on %s: expected %h, got %h", fname, want, seen);
      fail_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the edge's
  // nonblocking updates land, so both sides see the same handshake.
  // Output is checked first: a result leaving now belongs to an older byte.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t  want;
    rx_item_t item;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_echoes.size() == 0) begin
          if (fail_cnt < MAX_REPORTS)
            $display("result with nothing expected: tx_byte %h", tx_byte);
          fail_cnt++;
        end else begin
          want = pending_echoes.pop_front();
          check_field("tx_byte",         16'(want.tx_byte),         16'(tx_byte));
          check_field("tx_twice",        16'(want.tx_twice),        16'(tx_twice));
          check_field("run_flag",        16'(want.run_flag),        16'(run_flag));
          check_field("stop_flag",       16'(want.stop_flag),       16'(stop_flag));
          check_field("setpoints_valid", 16'(want.setpoints_valid), 16'(setpoints_valid));
          check_field("setpoint_a",      want.setpoint_a,           setpoint_a);
          check_field("setpoint_b",      want.setpoint_b,           setpoint_b);
          check_field("setpoint_c",      want.setpoint_c,           setpoint_c);
        end
      end
      if (in_valid && in_ready) begin
        item = offered_bytes.pop_front();
        want = parse_rx_byte(rx_byte);
        if (item.typed)
          want = item.exp;
        pending_echoes.push_back(want);
      end
    end
  end

  // Receiver back-pressure: one draw per cycle, percentage set by the phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Valid stays high across back-to-back transactions; it drops only
  // for a drawn idle gap or at the end, so it never sees two writes in one step.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input rx_item_t item);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    offered_bytes.push_back(item);
    in_valid <= 1'b1;
    rx_byte  <= item.rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic rx_item_t plain_row(input logic [7:0] b);
    rx_item_t r;
    r = '0;
    r.rx = b;
    return r;
  endfunction

  function automatic rx_item_t typed_row(input logic [7:0] b, input logic twice,
                                         input logic run, input logic stp,
                                         input logic vld,
                                         input logic signed [15:0] sp_a,
                                         input logic signed [15:0] sp_b,
                                         input logic signed [15:0] sp_c);
    rx_item_t r;
    r.rx                  = b;
    r.typed               = 1'b1;
    r.exp.tx_byte         = b;
    r.exp.tx_twice        = twice;
    r.exp.run_flag        = run;
    r.exp.stop_flag       = stp;
    r.exp.setpoints_valid = vld;
    r.exp.setpoint_a      = sp_a;
    r.exp.setpoint_b      = sp_b;
    r.exp.setpoint_c      = sp_c;
    return r;
  endfunction

  function automatic logic is_command(input logic [7:0] b);
    return (b == CMD_GO) || (b == CMD_STOP) || (b == CMD_SYNC);
  endfunction

  // Random frame byte, never a command; leans on the sign/magnitude edges.
  function automatic logic [7:0] frame_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       b = 8'h00;
        1:       b = 8'h80;
        2:       b = 8'h7f;
        default: b = 8'hff;
      endcase
    end else begin
      do b = 8'($urandom); while (is_command(b));
    end
    return b;
  endfunction

  function automatic logic [7:0] any_command();
    case ($urandom_range(0, 2))
      0:       return CMD_GO;
      1:       return CMD_STOP;
      default: return CMD_SYNC;
    endcase
  endfunction

  // Mostly well-formed frames (often opened by a sync), some with run/stop
  // bytes mixed in; the rest is truncated frames, lone commands and raw noise.
  task automatic send_random_stream(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned flen;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        if ($urandom_range(0, 1) == 0) begin
          send_byte(plain_row(CMD_SYNC));
          sent++;
        end
        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 6;
        for (k = 0; k < flen; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            send_byte(plain_row(($urandom_range(0, 1) == 0) ? CMD_GO : CMD_STOP));
            sent++;
          end
          send_byte(plain_row(frame_byte()));
          sent++;
        end
      end else if (pick < 88) begin
        send_byte(plain_row(any_command()));
        sent++;
      end else begin
        send_byte(plain_row(8'($urandom_range(0, 255))));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, three random phases, drain.
  // ---------------------------------------------------------------------------
  initial begin
    rx_item_t dir_table[$];
    int unsigned i;

    // After reset: flags clear, setpoints zero.
    dir_table.push_back(typed_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0));
    dir_table.push_back(typed_row(CMD_GO, 1'b0, 1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0));
    dir_table.push_back(typed_row(CMD_STOP, 1'b0, 1'b0, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0));
    // sync drops the stray frame byte above
    dir_table.push_back(typed_row(CMD_SYNC, 1'b1, 1'b0, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0));
    // Frame of extremes: +32767, -32767, negative zero.
    dir_table.push_back(plain_row(8'hff));
    dir_table.push_back(plain_row(8'h7f));
    dir_table.push_back(plain_row(8'hff));
    dir_table.push_back(plain_row(8'hff));
    dir_table.push_back(plain_row(8'h00));
    dir_table.push_back(typed_row(8'h80, 1'b0, 1'b0, 1'b1, 1'b1,
                                  16'sd32767, -16'sd32767, 16'sd0));
    // Frame with a go byte inside it; go does not disturb collection.
    dir_table.push_back(plain_row(8'h01));
    dir_table.push_back(plain_row(8'h00));
    dir_table.push_back(plain_row(CMD_GO));
    dir_table.push_back(plain_row(8'h00));
    dir_table.push_back(plain_row(8'h80));
    dir_table.push_back(plain_row(8'h01));
    dir_table.push_back(typed_row(8'h80, 1'b0, 1'b1, 1'b0, 1'b1,
                                  16'sd1, 16'sd0, -16'sd1));
    // Partial frame cut by sync, then an all-zero frame.
    dir_table.push_back(plain_row(8'h12));
    dir_table.push_back(plain_row(CMD_SYNC));
    for (i = 0; i < 5; i++)
      dir_table.push_back(plain_row(8'h00));
    dir_table.push_back(typed_row(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sender idles 28%, receiver 53%.
    foreach (dir_table[j])
      send_byte(dir_table[j]);
    send_random_stream(RANDOM_PER_PHASE);

    // Phase 2: roles swapped.
    send_idle_pct = 53;
    recv_idle_pct = 28;
    send_random_stream(RANDOM_PER_PHASE);

    // Phase 3: full rate both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_stream(RANDOM_PER_PHASE);

    in_valid <= 1'b0;
    while (pending_echoes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
